### rtl/coo_sparse_matrix_vector_multiply_assert.svh
// Assertion macros for the sparse matrix-vector block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef COO_SPARSE_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define COO_SPARSE_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

// Same-cycle implication.
`define CSPMV_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cspmv assertion failed");

// Next-cycle implication.
`define CSPMV_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cspmv assertion failed");

`endif

### rtl/cspmv_pkg.sv
package cspmv_pkg;

  localparam int VEC_DEPTH_DEF = 1024;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd2;

  localparam logic [10:0] NUM_ROWS_RST = 11'd1024;
  localparam logic [10:0] NUM_COLS_RST = 11'd1024;
  localparam logic [31:0] SCALE_RST    = 32'd1;

  typedef enum logic [2:0] {
    CMD_LOAD_X   = 3'd0,
    CMD_PRESET_Y = 3'd1,
    CMD_CLEAR_Y  = 3'd2,
    CMD_NONZERO  = 3'd3,
    CMD_READ_Y   = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [9:0]         row_index;
    logic [9:0]         col_index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] row_value;
    logic [9:0]         row_echo;
    logic               index_error;
  } out_item_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic cap;       // capture accepted transaction
    logic x_wr;      // write vector entry
    logic y_preset;  // write result row from transaction value
    logic nz_issue;  // read x and y, first multiply
    logic nz_mul;    // second multiply
    logic nz_acc;    // accumulate and write back
    logic rd_issue;  // read result row
    logic out_hit;   // present row read from memory
    logic out_miss;  // present zero row, error set
    logic err_set;
    logic err_clr;
    logic clr_init;  // restart sweep counter
    logic clr_wr;    // sweep one row
  } cspmv_ctrl_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic [2:0] command;
    logic       row_ok;
    logic       col_ok;
    logic       clr_last;
  } cspmv_stat_t;

endpackage

### rtl/cspmv_ctrl.sv
module cspmv_ctrl import cspmv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  cspmv_stat_t stat,
  output cspmv_ctrl_t ctrl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_NZ_MUL,
    S_NZ_ACC,
    S_RD_OUT,
    S_CLEAR
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;  // result valid bits swept after reset
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctrl.cap  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        case (cmd_t'(stat.command))
          CMD_LOAD_X: begin
            if (stat.col_ok) ctrl.x_wr = 1'b1;
            else ctrl.err_set = 1'b1;
          end
          CMD_PRESET_Y: begin
            if (stat.row_ok) ctrl.y_preset = 1'b1;
            else ctrl.err_set = 1'b1;
          end
          CMD_CLEAR_Y: begin
            ctrl.err_clr  = 1'b1;
            ctrl.clr_init = 1'b1;
            state_nxt     = S_CLEAR;
          end
          CMD_NONZERO: begin
            if (stat.row_ok && stat.col_ok) begin
              ctrl.nz_issue = 1'b1;
              state_nxt     = S_NZ_MUL;
            end else begin
              ctrl.err_set = 1'b1;
            end
          end
          CMD_READ_Y: begin
            if (stat.row_ok) begin
              ctrl.rd_issue = 1'b1;
              state_nxt     = S_RD_OUT;
            end else begin
              ctrl.err_set  = 1'b1;
              ctrl.out_miss = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_NZ_MUL: begin
        ctrl.nz_mul = 1'b1;
        state_nxt   = S_NZ_ACC;
      end
      S_NZ_ACC: begin
        ctrl.nz_acc = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_RD_OUT: begin
        ctrl.out_hit = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_CLEAR: begin
        ctrl.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/cspmv_dp.sv
module cspmv_dp import cspmv_pkg::*; #(
  parameter int VEC_DEPTH = VEC_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_item,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cspmv_ctrl_t           ctrl,
  output cspmv_stat_t           stat,
  output logic                  out_valid,
  output out_item_t             out_item
);

  localparam int AW = $clog2(VEC_DEPTH);

  // config
  logic [10:0] num_rows_r, num_cols_r;
  logic [31:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= NUM_ROWS_RST;
      num_cols_r <= NUM_COLS_RST;
      scale_r    <= SCALE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_NUM_ROWS: num_rows_r <= cfg_data[10:0];
        CFG_NUM_COLS: num_cols_r <= cfg_data[10:0];
        CFG_SCALE:    scale_r    <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  // captured transaction and range checks
  in_item_t item_r;
  logic     row_ok_r, col_ok_r;
  logic     row_ok, col_ok;

  assign row_ok = ({1'b0, in_item.row_index} < num_rows_r) &&
                  (int'(in_item.row_index) < VEC_DEPTH);
  assign col_ok = ({1'b0, in_item.col_index} < num_cols_r) &&
                  (int'(in_item.col_index) < VEC_DEPTH);

  always_ff @(posedge clk) begin
    if (ctrl.cap) begin
      item_r   <= in_item;
      row_ok_r <= row_ok;
      col_ok_r <= col_ok;
    end
  end

  logic [AW-1:0] row_a, col_a;
  assign row_a = AW'(item_r.row_index);
  assign col_a = AW'(item_r.col_index);

  // vector store
  logic [31:0] x_mem [VEC_DEPTH];
  logic [31:0] x_rd_r;

  always_ff @(posedge clk) begin
    if (ctrl.x_wr) x_mem[col_a] <= item_r.value;
    if (ctrl.nz_issue) x_rd_r <= x_mem[col_a];
  end

  // result store: {valid, data}
  logic [32:0]   y_mem [VEC_DEPTH];
  logic [32:0]   y_rd_r;
  logic          y_we;
  logic [AW-1:0] y_wa;
  logic [32:0]   y_wd;
  logic [AW-1:0] clr_cnt_r;

  logic [31:0] mul1_r, prod_r, acc, sum;

  assign acc = y_rd_r[32] ? y_rd_r[31:0] : 32'd0;
  assign sum = acc + prod_r;

  always_comb begin
    y_we = ctrl.clr_wr | ctrl.y_preset | ctrl.nz_acc;
    y_wa = ctrl.clr_wr ? clr_cnt_r : row_a;
    if (ctrl.clr_wr) y_wd = '0;
    else if (ctrl.y_preset) y_wd = {1'b1, item_r.value};
    else y_wd = {1'b1, sum};
  end

  always_ff @(posedge clk) begin
    if (y_we) y_mem[y_wa] <= y_wd;
    if (ctrl.nz_issue || ctrl.rd_issue) y_rd_r <= y_mem[row_a];
  end

  // two registered multiplies, low 32 bits kept
  always_ff @(posedge clk) begin
    if (ctrl.nz_issue) mul1_r <= scale_r * item_r.value;
    if (ctrl.nz_mul) prod_r <= mul1_r * x_rd_r;
  end

  // sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr_init) begin
      clr_cnt_r <= '0;
    end else if (ctrl.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // sticky error
  logic err_r;
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.err_clr) begin
      err_r <= 1'b0;
    end else if (ctrl.err_set) begin
      err_r <= 1'b1;
    end
  end

  // result register
  logic      out_valid_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.out_hit | ctrl.out_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_hit) begin
      out_item_r <= '{row_value: acc, row_echo: item_r.row_index, index_error: err_r};
    end else if (ctrl.out_miss) begin
      out_item_r <= '{row_value: 32'sd0, row_echo: item_r.row_index, index_error: 1'b1};
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign stat.command  = item_r.command;
  assign stat.row_ok   = row_ok_r;
  assign stat.col_ok   = col_ok_r;
  assign stat.clr_last = (clr_cnt_r == AW'(VEC_DEPTH - 1));

endmodule

### rtl/coo_sparse_matrix_vector_multiply.sv
// Coordinate-format sparse matrix times vector, 32-bit wrapping integers.
// A transaction is accepted when start is high and busy is low; one
// command runs at a time. Load-vector, preset-row, unknown codes and any
// command with an out-of-range index pass only through decode, read-row
// also passes a read-out state, a nonzero runs one result-memory read,
// two registered 32x32 multiplies and one write-back, and clear runs
// decode plus the sweep that clears one result valid bit per cycle. The
// same sweep runs after reset with busy high; configuration writes are
// taken at any time. A read result is driven on out_item for exactly one
// cycle with out_valid high, from a register loaded in the read-out state
// (in decode for an out-of-range row); the receiver cannot stall it, so
// it must sample out_item whenever out_valid is high.
`include "coo_sparse_matrix_vector_multiply_assert.svh"

module coo_sparse_matrix_vector_multiply import cspmv_pkg::*; #(
  parameter int VEC_DEPTH = VEC_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command transaction
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  // result transaction
  output logic                  out_valid,
  output out_item_t             out_item,
  // register writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cspmv_ctrl_t ctrl;
  cspmv_stat_t stat;

  // Sequencer: decode, memory access order, clear sweep.
  cspmv_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Stores, multiplier chain, config and result registers.
  cspmv_dp #(
    .VEC_DEPTH (VEC_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // An accepted command always occupies the block for the next cycle.
  `CSPMV_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // A result only follows a cycle of work on a read.
  `CSPMV_ASSERT_IMP(a_out_after_busy, out_valid, $past(busy))
  // Results are single-cycle strobes and never back to back.
  `CSPMV_ASSERT_NXT(a_out_strobe, out_valid, !out_valid)
  // The clear sweep never overlaps accepting a command.
  `CSPMV_ASSERT_IMP(a_clr_busy, ctrl.clr_wr, busy && !ctrl.cap)

endmodule

### test/tb_coo_sparse_matrix_vector_multiply.sv
module tb_coo_sparse_matrix_vector_multiply;
  import cspmv_pkg::*;

  // Quiet-cycle budget: a clear sweep plus the settle pause before a register
  // write plus the longest sender gap fit many times over.
  localparam int STALL_LIMIT = 20000;
  // Cycles to let a clear sweep finish before touching registers.
  localparam int SETTLE_CYCLES = VEC_DEPTH_DEF + 16;
  localparam int TAIL_CYCLES = 16;
  localparam int NUM_PHASES = 7;

  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // Register index past the end of the register list; writes must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_SCALE + 1'b1;
  // Command codes with no meaning; the block must ignore them.
  localparam int FIRST_UNUSED_CODE = int'(CMD_READ_Y) + 1;
  localparam int LAST_UNUSED_CODE = (1 << $bits(cmd_t)) - 1;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow copy of the vector, the result rows, their valid bits,
  // the sticky error flag and the registers. Every accepted command updates
  // the shadow; every read pushes the row it must return.
  // --------------------------------------------------------------------------
  class spmv_board;
    logic [31:0] x_vec [VEC_DEPTH_DEF];
    logic [31:0] y_rows [VEC_DEPTH_DEF];
    bit          y_written [VEC_DEPTH_DEF];
    bit          sticky_err;
    logic [10:0] rows_cfg;
    logic [10:0] cols_cfg;
    logic [31:0] scale_cfg;
    out_item_t   pending_rows [$];
    int          mismatches;

    function new();
      foreach (y_written[i]) y_written[i] = 1'b0;
      sticky_err = 1'b0;
      rows_cfg = NUM_ROWS_RST;
      cols_cfg = NUM_COLS_RST;
      scale_cfg = SCALE_RST;
      mismatches = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_NUM_ROWS: rows_cfg = data[10:0];
        CFG_NUM_COLS: cols_cfg = data[10:0];
        CFG_SCALE:    scale_cfg = data[31:0];
        default: ;
      endcase
    endfunction

    function bit row_in(logic [9:0] r);
      return ({1'b0, r} < rows_cfg) && (int'(r) < VEC_DEPTH_DEF);
    endfunction

    function bit col_in(logic [9:0] c);
      return ({1'b0, c} < cols_cfg) && (int'(c) < VEC_DEPTH_DEF);
    endfunction

    function void note_command(in_item_t t);
      logic [31:0] acc;
      logic [31:0] prod;
      out_item_t   rd;
      case (t.command)
        CMD_LOAD_X: begin
          if (col_in(t.col_index)) x_vec[t.col_index] = t.value;
          else sticky_err = 1'b1;
        end
        CMD_PRESET_Y: begin
          if (row_in(t.row_index)) begin
            y_rows[t.row_index] = t.value;
            y_written[t.row_index] = 1'b1;
          end else begin
            sticky_err = 1'b1;
          end
        end
        CMD_CLEAR_Y: begin
          foreach (y_written[i]) y_written[i] = 1'b0;
          sticky_err = 1'b0;
        end
        CMD_NONZERO: begin
          if (row_in(t.row_index) && col_in(t.col_index)) begin
            // Unwritten row counts as zero; all products wrap at 32 bits.
            acc = y_written[t.row_index] ? y_rows[t.row_index] : 32'd0;
            prod = scale_cfg * t.value;
            prod = prod * x_vec[t.col_index];
            y_rows[t.row_index] = acc + prod;
            y_written[t.row_index] = 1'b1;
          end else begin
            sticky_err = 1'b1;
          end
        end
        CMD_READ_Y: begin
          rd.row_value = '0;
          if (row_in(t.row_index)) begin
            if (y_written[t.row_index]) rd.row_value = y_rows[t.row_index];
          end else begin
            sticky_err = 1'b1;
          end
          rd.row_echo = t.row_index;
          rd.index_error = sticky_err;
          pending_rows.push_back(rd);
        end
        default: ;
      endcase
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_read(out_item_t got);
      out_item_t want;
      if (pending_rows.size() == 0) begin
        flag($sformatf("unexpected read transaction: value %0d echo %0d err %0b",
                       got.row_value, got.row_echo, got.index_error));
        return;
      end
      want = pending_rows.pop_front();
      if (got.row_value !== want.row_value || got.row_echo !== want.row_echo ||
          got.index_error !== want.index_error)
        flag($sformatf("read row %0d: expected value %0d echo %0d err %0b, got value %0d echo %0d err %0b",
                       want.row_echo, want.row_value, want.row_echo, want.index_error,
                       got.row_value, got.row_echo, got.index_error));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_item = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  coo_sparse_matrix_vector_multiply i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  spmv_board board = new();

  // Driver-side view of the configuration, as effective limits (0..1024).
  int cur_rows = VEC_DEPTH_DEF;
  int cur_cols = VEC_DEPTH_DEF;
  // Columns that hold a loaded vector entry; nonzeros only read these.
  int loaded_cols [$];
  bit no_gaps = 1'b0;
  int quiet_cycles = 0;

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the driver's
  // nonblocking updates land, so it sees exactly what the block sampled.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.note_command(in_item);
      if (out_valid) board.check_read(out_item);
      if (cfg_wr_en) board.write_register(cfg_index, cfg_data);
      if ((start && !busy) || out_valid || cfg_wr_en) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Build a transaction; fields the command does not use carry whatever the caller passes.
  function automatic in_item_t cmd_item(logic [2:0] code, int r, int c, logic [31:0] v);
    in_item_t t;
    t.command = code;
    t.row_index = 10'(r);
    t.col_index = 10'(c);
    t.value = v;
    return t;
  endfunction

  // Mostly in range and clustered low so rows get hit repeatedly; some spread
  // across the whole range, some out of range when the limit allows it.
  function automatic int pick_index(int limit);
    if (limit == 0) return $urandom_range(0, VEC_DEPTH_DEF - 1);
    if (limit < VEC_DEPTH_DEF && $urandom_range(0, 99) < 12)
      return $urandom_range(limit, VEC_DEPTH_DEF - 1);
    if ($urandom_range(0, 3) != 0) return $urandom_range(0, (limit < 24 ? limit : 24) - 1);
    return $urandom_range(0, limit - 1);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 19))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return ALL_ONES;
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_command();
    in_item_t t;
    int       pick;
    t = cmd_item(3'($urandom), $urandom, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    // No vector entry loaded yet: a nonzero would read garbage, load instead.
    if (pick >= 31 && pick < 60 && loaded_cols.size() == 0) pick = 0;
    if (pick < 16) begin
      t.command = CMD_LOAD_X;
      t.col_index = 10'(pick_index(cur_cols));
      t.value = pick_value();
    end else if (pick < 28) begin
      t.command = CMD_PRESET_Y;
      t.row_index = 10'(pick_index(cur_rows));
      t.value = pick_value();
    end else if (pick < 31) begin
      t.command = CMD_CLEAR_Y;
    end else if (pick < 60) begin
      t.command = CMD_NONZERO;
      t.row_index = 10'(pick_index(cur_rows));
      if (cur_cols < VEC_DEPTH_DEF && $urandom_range(0, 9) == 0)
        t.col_index = 10'($urandom_range(cur_cols, VEC_DEPTH_DEF - 1));
      else
        t.col_index = 10'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
      t.value = pick_value();
    end else if (pick < 94) begin
      t.command = CMD_READ_Y;
      t.row_index = 10'(pick_index(cur_rows));
    end else begin
      t.command = 3'($urandom_range(FIRST_UNUSED_CODE, LAST_UNUSED_CODE));
    end
    return t;
  endfunction

  // Hold the transaction until the block takes it (start high, busy low).
  task automatic send_command(in_item_t t);
    start <= 1'b1;
    in_item <= t;
    do @(posedge clk); while (busy);
    if (t.command == CMD_LOAD_X && int'(t.col_index) < cur_cols)
      loaded_cols.push_back(int'(t.col_index));
  endtask

  // Random sender gap: mostly none or short, now and then long.
  task automatic pause_sender();
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    gap = 0;
    if (!no_gaps) begin
      if (pick >= 92) gap = $urandom_range(8, 40);
      else if (pick >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every pending read has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (board.pending_rows.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Registers change only with the block idle: reads drained, then a pause
  // long enough for a clear sweep that may still be running. Upper bits of
  // the 11-bit registers carry junk, which the block must drop.
  task automatic configure(int rows, int cols, logic [31:0] scl);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_NUM_ROWS, ($urandom & ~32'h7FF) | 32'(rows & 'h7FF));
    write_reg(CFG_NUM_COLS, ($urandom & ~32'h7FF) | 32'(cols & 'h7FF));
    write_reg(CFG_SCALE, scl);
    write_reg(CFG_SPARE, $urandom);
    cfg_wr_en <= 1'b0;
    cur_rows = (rows & 'h7FF) > VEC_DEPTH_DEF ? VEC_DEPTH_DEF : (rows & 'h7FF);
    cur_cols = (cols & 'h7FF) > VEC_DEPTH_DEF ? VEC_DEPTH_DEF : (cols & 'h7FF);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_item_t    directed [$];
    int          phase_rows [NUM_PHASES];
    int          phase_cols [NUM_PHASES];
    logic [31:0] phase_scale [NUM_PHASES];
    int          phase_items [NUM_PHASES];

    // Settings swept: small square, single row/col, all-out-of-range,
    // full size with most-negative scale, row count past the store depth,
    // a random scale, and a narrow column window.
    phase_rows = '{24, 1, 0, 1024, 2047, 300, 1024};
    phase_cols = '{24, 1, 0, 1024, 7, 1024, 5};
    phase_scale = '{32'd3, ALL_ONES, 32'd0, MOST_NEG, MOST_POS, $urandom, 32'd1};
    phase_items = '{260, 200, 60, 260, 220, 240, 160};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset configuration: empty read, ignored codes, extreme
    // operands, accumulate onto a preset, nonzero onto an untouched row,
    // read of a never-written row, clear.
    directed.push_back(cmd_item(CMD_READ_Y, 0, 0, 0));
    directed.push_back(cmd_item(3'(FIRST_UNUSED_CODE), 1, 1, MOST_NEG));
    directed.push_back(cmd_item(3'(LAST_UNUSED_CODE), 1023, 1023, ALL_ONES));
    directed.push_back(cmd_item(CMD_LOAD_X, 1023, 0, MOST_POS));
    directed.push_back(cmd_item(CMD_LOAD_X, 0, 1023, MOST_NEG));
    directed.push_back(cmd_item(CMD_LOAD_X, 512, 1, ALL_ONES));
    directed.push_back(cmd_item(CMD_PRESET_Y, 1023, 0, MOST_NEG));
    directed.push_back(cmd_item(CMD_PRESET_Y, 0, 1023, 32'd5));
    directed.push_back(cmd_item(CMD_NONZERO, 0, 0, MOST_NEG));
    directed.push_back(cmd_item(CMD_NONZERO, 1023, 1023, ALL_ONES));
    directed.push_back(cmd_item(CMD_NONZERO, 2, 1, MOST_POS));
    directed.push_back(cmd_item(CMD_READ_Y, 0, 0, 0));
    directed.push_back(cmd_item(CMD_READ_Y, 1023, 0, 0));
    directed.push_back(cmd_item(CMD_READ_Y, 2, 0, 0));
    directed.push_back(cmd_item(CMD_READ_Y, 3, 0, 0));
    directed.push_back(cmd_item(CMD_CLEAR_Y, 0, 0, 0));
    directed.push_back(cmd_item(CMD_READ_Y, 0, 0, 0));
    foreach (directed[i]) begin
      send_command(directed[i]);
      pause_sender();
    end

    // Directed, tiny window: every out-of-range flavor, the sticky flag
    // surviving a good read, and clear dropping it.
    configure(4, 4, 32'hFFFF_FFFE);
    directed.delete();
    directed.push_back(cmd_item(CMD_LOAD_X, 0, 4, MOST_POS));
    directed.push_back(cmd_item(CMD_PRESET_Y, 5, 0, 32'd7));
    directed.push_back(cmd_item(CMD_NONZERO, 9, 1, 32'd3));
    directed.push_back(cmd_item(CMD_NONZERO, 1, 700, 32'd3));
    directed.push_back(cmd_item(CMD_NONZERO, 3, 1, MOST_POS));
    directed.push_back(cmd_item(CMD_READ_Y, 700, 0, 0));
    directed.push_back(cmd_item(CMD_READ_Y, 3, 0, 0));
    directed.push_back(cmd_item(CMD_CLEAR_Y, 0, 0, 0));
    directed.push_back(cmd_item(CMD_READ_Y, 3, 0, 0));
    foreach (directed[i]) begin
      send_command(directed[i]);
      pause_sender();
    end

    // Random phases, each under its own register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      configure(phase_rows[p], phase_cols[p], phase_scale[p]);
      for (int k = 0; k < phase_items[p]; k++) begin
        // Alternate stretches of back-to-back traffic with gappy traffic.
        if (k % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        // Occasionally let the result side run dry mid-phase.
        if ($urandom_range(0, 99) == 0) drain();
        send_command(make_command());
        pause_sender();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending_rows.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/cspmv_pkg.sv
rtl/cspmv_ctrl.sv
rtl/cspmv_dp.sv
rtl/coo_sparse_matrix_vector_multiply.sv
test/tb_coo_sparse_matrix_vector_multiply.sv
